@@ rtl/pci2d_pkg.sv @@
// ----------------------------------------------------------------------------
// pci2d_pkg
// Shared types, codes and constants of the planar pose composition/inverse
// unit: operation codes, quarter-turn codes, CORDIC gain and arctangents.
// ----------------------------------------------------------------------------
package pci2d_pkg;

   // Operation selector carried on req_tuser
   localparam logic FUNC_COMPOSE = 1'b0;
   localparam logic FUNC_INVERSE = 1'b1;

   // Quarter of the turn for headings that are exact multiples of pi/2
   typedef enum logic [1:0] {
      QTR_0   = 2'd0,
      QTR_90  = 2'd1,
      QTR_180 = 2'd2,
      QTR_270 = 2'd3
   } quarter_type;

   // Trig datapath width: Q1.30 with headroom, signed
   localparam int TRIG_W = 33;
   // Turn width used inside the rotator (2^32 = 2*pi)
   localparam int TURN_W = 32;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE    = 33'sd1073741824;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

   // atan(2^-i) in 32-bit turn units
   function automatic logic [TURN_W-1:0] atan_turn(input int idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/pci2d_cordic.sv @@
// ----------------------------------------------------------------------------
// pci2d_cordic
// Pipelined rotation-mode CORDIC: one iteration per register stage. Gives
// cos and sin of a binary angle in Q1.30, with exact values at quarter turns.
// Side data travels alongside so the caller sees it next to its trig values.
// ----------------------------------------------------------------------------
module pci2d_cordic import pci2d_pkg::*; #(
   parameter int ANGLE_BITS  = 16,
   parameter int TRIG_STAGES = 16,
   parameter int SIDE_W      = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ANGLE_BITS-1:0]    in_angle,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [TRIG_W-1:0] out_cos,
   output logic signed [TRIG_W-1:0] out_sin,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int NS = TRIG_STAGES + 1;

   logic signed [TRIG_W-1:0] x_ff [NS];
   logic signed [TRIG_W-1:0] y_ff [NS];
   logic signed [TRIG_W-1:0] z_ff [NS];
   logic                     valid_ff [NS];
   logic                     quarter_ff [NS];
   quarter_type              qcode_ff [NS];
   logic                     flip_ff [NS];
   logic [SIDE_W-1:0]        side_ff [NS];

   logic [TURN_W-1:0]        turn;
   logic [TURN_W-1:0]        zturn;
   logic                     flip0_in;
   logic                     quarter0_in;
   logic signed [TRIG_W-1:0] z0_in;

   // Widen angle to a full turn, fold the left half plane by pi
   always_comb begin
      turn        = {in_angle, {(TURN_W-ANGLE_BITS){1'b0}}};
      quarter0_in = (turn[TURN_W-3:0] == '0);
      flip0_in    = turn[TURN_W-1] ^ turn[TURN_W-2];
      zturn       = {turn[TURN_W-1] ^ flip0_in, turn[TURN_W-2:0]};
      z0_in       = {zturn[TURN_W-1], zturn};
   end

   // Entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]       <= CORDIC_GAIN;
         y_ff[0]       <= '0;
         z_ff[0]       <= z0_in;
         quarter_ff[0] <= quarter0_in;
         qcode_ff[0]   <= quarter_type'(turn[TURN_W-1:TURN_W-2]);
         flip_ff[0]    <= flip0_in;
         side_ff[0]    <= in_side;
      end
   end

   // One micro-rotation per stage, shifts floor
   for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_iter
      logic signed [TRIG_W-1:0] x_in, y_in, z_in;
      logic signed [TRIG_W-1:0] atan_k;

      always_comb begin
         atan_k = TRIG_W'(atan_turn(k));
         if (!z_ff[k][TRIG_W-1]) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - atan_k;
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + atan_k;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            x_ff[k+1]       <= x_in;
            y_ff[k+1]       <= y_in;
            z_ff[k+1]       <= z_in;
            quarter_ff[k+1] <= quarter_ff[k];
            qcode_ff[k+1]   <= qcode_ff[k];
            flip_ff[k+1]    <= flip_ff[k];
            side_ff[k+1]    <= side_ff[k];
         end
      end
   end

   logic signed [TRIG_W-1:0] cos_in, sin_in;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic                     fvalid_ff;
   logic [SIDE_W-1:0]        fside_ff;

   // Exact quarter-turn values, else unfold the CORDIC result
   always_comb begin
      if (quarter_ff[TRIG_STAGES]) begin
         case (qcode_ff[TRIG_STAGES])
            QTR_0:   begin cos_in = TRIG_ONE;  sin_in = '0;        end
            QTR_90:  begin cos_in = '0;        sin_in = TRIG_ONE;  end
            QTR_180: begin cos_in = -TRIG_ONE; sin_in = '0;        end
            QTR_270: begin cos_in = '0;        sin_in = -TRIG_ONE; end
            default: begin cos_in = TRIG_ONE;  sin_in = '0;        end
         endcase
      end else if (flip_ff[TRIG_STAGES]) begin
         cos_in = -x_ff[TRIG_STAGES];
         sin_in = -y_ff[TRIG_STAGES];
      end else begin
         cos_in = x_ff[TRIG_STAGES];
         sin_in = y_ff[TRIG_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= 1'b0;
      end else if (en) begin
         fvalid_ff <= valid_ff[TRIG_STAGES];
      end
      if (en) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         fside_ff <= side_ff[TRIG_STAGES];
      end
   end

   assign out_valid = fvalid_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = fside_ff;

endmodule

@@ rtl/pose_compose_inverse_2d.sv @@
// ----------------------------------------------------------------------------
// pose_compose_inverse_2d
// Planar pose arithmetic: compose pose A then B, or invert pose A.
//
// Request channel req_*: tuser selects the operation (0 compose, 1 inverse
// of A), tdata carries poses A and B. Response channel rsp_*: tdata carries
// the resulting pose, tuser the saturation flag. Positions are signed fixed
// point, headings are binary angles that wrap for free.
// Path: the accepting edge loads the entry stage; a request then passes one
// CORDIC iteration per stage, the trig select, operand magnitude, split
// multiply, rounding, and the sum/saturate output register, which drives
// rsp_tvalid. Throughput: one request per cycle while req_tready is high,
// set by the fully pipelined CORDIC and multiplier datapath.
// Reset clears all valid bits; the block then accepts at once.
// Stall: the output register is backed by a one-entry skid register. The
// pipeline keeps moving while a result waits; it holds (req_tready low)
// only once the skid register is also full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pose_compose_inverse_2d import pci2d_pkg::*; #(
   parameter int POS_WIDTH   = 32,
   parameter int ANGLE_BITS  = 16,
   parameter int TRIG_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   // a_x, a_y, a_heading, b_x, b_y, b_heading, zero fill
   input  logic [((4*POS_WIDTH+2*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   // func
   input  logic [0:0] req_tuser,
   input  logic       req_tvalid,
   output logic       req_tready,
   // res_x, res_y, res_heading, zero fill
   output logic [((2*POS_WIDTH+ANGLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // overflow
   output logic [0:0] rsp_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready
);

   localparam int W      = POS_WIDTH;
   localparam int A      = ANGLE_BITS;
   localparam int OUT_BITS = 2*W + A;
   localparam int SIDE_W = 1 + 4*W + A;
   localparam int HALF   = (W + 1) / 2;
   localparam int HW     = W - HALF;
   localparam int MAG_T  = TRIG_W - 1;
   localparam int PL_W   = HALF + MAG_T;
   localparam int PH_W   = HW + MAG_T;
   localparam int ACC_W  = W + MAG_T + 1;
   localparam int R_W    = ACC_W - 30;
   localparam int PW     = R_W + 1;
   localparam int SW     = PW + 2;

   logic en;

   // Unpack request
   logic              func;
   logic signed [W-1:0] a_x, a_y, b_x, b_y;
   logic [A-1:0]      a_heading, b_heading, rh;
   logic [SIDE_W-1:0] side_in;

   always_comb begin
      func      = req_tuser[0];
      a_x       = req_tdata[W-1:0];
      a_y       = req_tdata[2*W-1:W];
      a_heading = req_tdata[2*W+A-1:2*W];
      b_x       = req_tdata[3*W+A-1:2*W+A];
      b_y       = req_tdata[4*W+A-1:3*W+A];
      b_heading = req_tdata[4*W+2*A-1:4*W+A];
      // Heading result wraps modulo 2^A
      if (func == FUNC_INVERSE) begin
         rh = A'(-a_heading);
      end else begin
         rh = A'(a_heading + b_heading);
      end
      side_in = {rh, b_y, b_x, a_y, a_x, func};
   end

   logic                     t_valid;
   logic signed [TRIG_W-1:0] t_cos, t_sin;
   logic [SIDE_W-1:0]        t_side;

   pci2d_cordic #(
      .ANGLE_BITS  (A),
      .TRIG_STAGES (TRIG_STAGES),
      .SIDE_W      (SIDE_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_angle  (a_heading),
      .in_side   (side_in),
      .out_valid (t_valid),
      .out_cos   (t_cos),
      .out_sin   (t_sin),
      .out_side  (t_side)
   );

   // Stage A: operand select, magnitudes and signs
   logic                t_func;
   logic signed [W-1:0] t_ax, t_ay, t_bx, t_by, t_u, t_v;
   logic [A-1:0]        t_rh;
   logic [W-1:0]        mu_in, mv_in;
   logic [MAG_T-1:0]    mc_in, ms_in;

   always_comb begin
      {t_rh, t_by, t_bx, t_ay, t_ax, t_func} = t_side;
      t_u   = (t_func == FUNC_INVERSE) ? t_ax : t_bx;
      t_v   = (t_func == FUNC_INVERSE) ? t_ay : t_by;
      mu_in = t_u[W-1] ? W'(-t_u) : W'(t_u);
      mv_in = t_v[W-1] ? W'(-t_v) : W'(t_v);
      mc_in = t_cos[TRIG_W-1] ? MAG_T'(-t_cos) : MAG_T'(t_cos);
      ms_in = t_sin[TRIG_W-1] ? MAG_T'(-t_sin) : MAG_T'(t_sin);
   end

   logic                a_valid_ff, a_func_ff;
   logic signed [W-1:0] a_ax_ff, a_ay_ff;
   logic [A-1:0]        a_rh_ff;
   logic [W-1:0]        a_mu_ff, a_mv_ff;
   logic [MAG_T-1:0]    a_mc_ff, a_ms_ff;
   logic                a_su_ff, a_sv_ff, a_sc_ff, a_ss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= t_valid;
      end
      if (en) begin
         a_func_ff <= t_func;
         a_ax_ff   <= t_ax;
         a_ay_ff   <= t_ay;
         a_rh_ff   <= t_rh;
         a_mu_ff   <= mu_in;
         a_mv_ff   <= mv_in;
         a_mc_ff   <= mc_in;
         a_ms_ff   <= ms_in;
         a_su_ff   <= t_u[W-1];
         a_sv_ff   <= t_v[W-1];
         a_sc_ff   <= t_cos[TRIG_W-1];
         a_ss_ff   <= t_sin[TRIG_W-1];
      end
   end

   // Stage M: four products u*c, v*s, u*s, v*c, each split in halves
   logic [W-1:0]     mm [4];
   logic [MAG_T-1:0] tm [4];
   logic             ng [4];

   always_comb begin
      mm[0] = a_mu_ff; tm[0] = a_mc_ff; ng[0] = a_su_ff ^ a_sc_ff;
      mm[1] = a_mv_ff; tm[1] = a_ms_ff; ng[1] = a_sv_ff ^ a_ss_ff;
      mm[2] = a_mu_ff; tm[2] = a_ms_ff; ng[2] = a_su_ff ^ a_ss_ff;
      mm[3] = a_mv_ff; tm[3] = a_mc_ff; ng[3] = a_sv_ff ^ a_sc_ff;
   end

   logic [PL_W-1:0]     m_pl_ff [4];
   logic [PH_W-1:0]     m_ph_ff [4];
   logic                m_neg_ff [4];
   logic                m_valid_ff, m_func_ff;
   logic signed [W-1:0] m_ax_ff, m_ay_ff;
   logic [A-1:0]        m_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= a_valid_ff;
      end
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            m_pl_ff[j]  <= PL_W'(mm[j][HALF-1:0]) * PL_W'(tm[j]);
            m_ph_ff[j]  <= PH_W'(mm[j][W-1:HALF]) * PH_W'(tm[j]);
            m_neg_ff[j] <= ng[j];
         end
         m_func_ff <= a_func_ff;
         m_ax_ff   <= a_ax_ff;
         m_ay_ff   <= a_ay_ff;
         m_rh_ff   <= a_rh_ff;
      end
   end

   // Stage R: join halves, round to nearest (ties away), apply sign
   logic [ACC_W-1:0]     acc [4];
   logic signed [PW-1:0] prod_in [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc[j] = (ACC_W'(m_ph_ff[j]) << HALF) + ACC_W'(m_pl_ff[j])
                  + (ACC_W'(1) << 29);
         prod_in[j] = m_neg_ff[j] ? -$signed({1'b0, acc[j][ACC_W-1:30]})
                                  :  $signed({1'b0, acc[j][ACC_W-1:30]});
      end
   end

   logic signed [PW-1:0] r_prod_ff [4];
   logic                 r_valid_ff, r_func_ff;
   logic signed [W-1:0]  r_ax_ff, r_ay_ff;
   logic [A-1:0]         r_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff <= m_valid_ff;
      end
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            r_prod_ff[j] <= prod_in[j];
         end
         r_func_ff <= m_func_ff;
         r_ax_ff   <= m_ax_ff;
         r_ay_ff   <= m_ay_ff;
         r_rh_ff   <= m_rh_ff;
      end
   end

   // Stage S: sums and saturation
   logic signed [SW-1:0] sum_x, sum_y;
   logic                 fit_x, fit_y;
   logic [W-1:0]         sx, sy;
   logic                 ovf;

   always_comb begin
      if (r_func_ff == FUNC_INVERSE) begin
         sum_x = -SW'(r_prod_ff[0]) - SW'(r_prod_ff[1]);
         sum_y =  SW'(r_prod_ff[2]) - SW'(r_prod_ff[3]);
      end else begin
         sum_x = SW'(r_ax_ff) + SW'(r_prod_ff[0]) - SW'(r_prod_ff[1]);
         sum_y = SW'(r_ay_ff) + SW'(r_prod_ff[2]) + SW'(r_prod_ff[3]);
      end
      fit_x = (sum_x[SW-1:W-1] == '0) || (sum_x[SW-1:W-1] == '1);
      fit_y = (sum_y[SW-1:W-1] == '0) || (sum_y[SW-1:W-1] == '1);
      sx = fit_x ? sum_x[W-1:0]
                 : (sum_x[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
      sy = fit_y ? sum_y[W-1:0]
                 : (sum_y[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
      ovf = !fit_x || !fit_y;
   end

   // Output register with skid entry
   logic         out_valid_ff, skid_valid_ff;
   logic [W-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic [A-1:0] out_h_ff, skid_h_ff;
   logic         out_ovf_ff, skid_ovf_ff;
   logic         take, push;

   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && rsp_tready;
   assign push = en && r_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_x_ff   <= skid_x_ff;
            out_y_ff   <= skid_y_ff;
            out_h_ff   <= skid_h_ff;
            out_ovf_ff <= skid_ovf_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_x_ff   <= sx;
            out_y_ff   <= sy;
            out_h_ff   <= r_rh_ff;
            out_ovf_ff <= ovf;
         end else begin
            skid_x_ff   <= sx;
            skid_y_ff   <= sy;
            skid_h_ff   <= r_rh_ff;
            skid_ovf_ff <= ovf;
         end
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ovf_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[OUT_BITS-1:0] = {out_h_ff, out_y_ff, out_x_ff};
   end

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_ovf_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         out_x_ff == {1'b1, {(W-1){1'b0}}} || out_x_ff == {1'b0, {(W-1){1'b1}}} ||
         out_y_ff == {1'b1, {(W-1){1'b0}}} || out_y_ff == {1'b0, {(W-1){1'b1}}})
      else $error("overflow flagged without a clamped position");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready && !skid_valid_ff && r_valid_ff |=> skid_valid_ff)
      else $error("result dropped on stall");

endmodule

@@ bench/tb_pose_compose_inverse_2d.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pose_compose_inverse_2d
// Self-checking bench for the planar pose unit. A directed table covers
// quarter turns, heading wrap, saturation and CORDIC angles; a random run in
// three idling phases follows. Every response is compared field by field
// against a typed result or a bit-exact CORDIC/rounding predictor, in request order.
// ----------------------------------------------------------------------------
module tb_pose_compose_inverse_2d;
   import pci2d_pkg::*;

   localparam int N_STAGES = 16;
   localparam int N_RANDOM = 1830;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [15:0] HDG_PI  = 16'sh8000;
   localparam logic signed [15:0] HDG_Q1  = 16'sh4000;
   localparam logic signed [15:0] HDG_Q3  = 16'shC000;

   typedef struct packed {
      logic                func;
      logic signed [31:0]  ax, ay;
      logic signed [15:0]  ah;
      logic signed [31:0]  bx, by;
      logic signed [15:0]  bh;
   } pose_req_type;

   typedef struct packed {
      logic signed [31:0]  rx, ry;
      logic signed [15:0]  rh;
      logic                ovf;
   } pose_res_type;

   logic         clock;
   logic         reset;
   logic [159:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;

   pose_res_type pending_poses[$];
   pose_req_type table_req[$];
   pose_res_type table_res[$];
   bit           table_typed[$];
   int           send_idle;
   int           recv_idle;
   int           n_rsp;
   bit           failed;

   pose_compose_inverse_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // round(v * t / 2^30), ties away from zero
   function automatic longint scale_by_trig(longint v, longint t);
      longint unsigned mag_v, mag_t, prod;
      bit neg;
      neg   = (v < 0) != (t < 0);
      mag_v = (v < 0) ? -v : v;
      mag_t = (t < 0) ? -t : t;
      prod  = (mag_v * mag_t + (64'd1 << 29)) >> 30;
      return neg ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint clamp_pos(longint v, inout bit ovf);
      if (v > longint'(POS_MAX)) begin
         ovf = 1'b1;
         return POS_MAX;
      end
      if (v < longint'(POS_MIN)) begin
         ovf = 1'b1;
         return POS_MIN;
      end
      return v;
   endfunction

   // Cosine and sine of a binary angle in Q1.30
   function automatic void heading_trig(logic [15:0] hdg, output longint c, output longint s);
      logic [31:0] turn;
      longint x, y, z, dx, dy;
      bit flip;
      quarter_type qtr;
      turn = {hdg, 16'h0000};
      if (turn[29:0] == '0) begin
         qtr = quarter_type'(turn[31:30]);
         case (qtr)
            QTR_0:   begin c = TRIG_ONE;  s = 0;         end
            QTR_90:  begin c = 0;         s = TRIG_ONE;  end
            QTR_180: begin c = -TRIG_ONE; s = 0;         end
            default: begin c = 0;         s = -TRIG_ONE; end
         endcase
         return;
      end
      flip = ((turn + 32'h4000_0000) & 32'h8000_0000) != 0;
      if (flip) turn = turn + 32'h8000_0000;
      z = longint'($signed(turn));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < N_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(atan_turn(i));
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(atan_turn(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic pose_res_type predict_pose(pose_req_type r);
      pose_res_type res;
      longint c, s, sx, sy;
      bit ovf;
      ovf = 1'b0;
      heading_trig(r.ah, c, s);
      if (r.func == FUNC_COMPOSE) begin
         sx = r.ax + scale_by_trig(r.bx, c) - scale_by_trig(r.by, s);
         sy = r.ay + scale_by_trig(r.bx, s) + scale_by_trig(r.by, c);
         res.rh = r.ah + r.bh;
      end else begin
         sx = -(scale_by_trig(r.ax, c) + scale_by_trig(r.ay, s));
         sy = scale_by_trig(r.ax, s) - scale_by_trig(r.ay, c);
         res.rh = -r.ah;
      end
      res.rx  = 32'(clamp_pos(sx, ovf));
      res.ry  = 32'(clamp_pos(sy, ovf));
      res.ovf = ovf;
      return res;
   endfunction

   function automatic void add_row(pose_req_type r, bit typed, pose_res_type res);
      table_req.push_back(r);
      table_typed.push_back(typed);
      table_res.push_back(res);
   endfunction

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(9))
         0:       return POS_MAX;
         1:       return POS_MIN;
         2:       return '0;
         3, 4, 5: return $signed($urandom) >>> $urandom_range(8, 20);
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_hdg();
      if ($urandom_range(7) == 0) return {2'($urandom_range(3)), 14'h0};
      return 16'($urandom);
   endfunction

   // Offer one request, idling at random first; record the expected pose
   task automatic send_pose(pose_req_type r, bit typed, pose_res_type res);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {r.bh, r.by, r.bx, r.ah, r.ay, r.ax};
      do @(posedge clock); while (!req_tready);
      pending_poses.push_back(typed ? res : predict_pose(r));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
   endtask

   // Response side: random back-pressure plus one long hold-off
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!held && n_rsp >= 300) begin
            held = 1'b1;
            hold = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      pose_res_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tuser[0]};
         n_rsp <= n_rsp + 1;
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            failed = 1'b1;
         end else begin
            want = pending_poses.pop_front();
            if (got.rx !== want.rx || got.ry !== want.ry ||
                got.rh !== want.rh || got.ovf !== want.ovf) begin
               $display("%0t: expected x=%0d y=%0d h=%0d ovf=%0d, got x=%0d y=%0d h=%0d ovf=%0d",
                        $time, want.rx, want.ry, want.rh, want.ovf,
                        got.rx, got.ry, got.rh, got.ovf);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("pose_compose_inverse_2d: mismatch");
      $finish;
   end

   initial begin
      pose_req_type r;
      pose_res_type none;
      int waited;
      none       = '0;
      failed     = 1'b0;
      n_rsp      = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      send_idle  = 37;
      recv_idle  = 51;

      // Directed rows: typed results where exact, the rest predicted
      add_row({FUNC_COMPOSE, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0},
              1, {32'sd0, 32'sd0, 16'sd0, 1'b0});
      add_row({FUNC_COMPOSE, 32'sd65536, 32'sd131072, 16'sd0, 32'sd196608, -32'sd65536, 16'sd256},
              1, {32'sd262144, 32'sd65536, 16'sd256, 1'b0});
      add_row({FUNC_COMPOSE, 32'sd0, 32'sd0, HDG_Q1, 32'sd65536, 32'sd0, 16'sd0},
              1, {32'sd0, 32'sd65536, HDG_Q1, 1'b0});
      add_row({FUNC_COMPOSE, 32'sd0, 32'sd0, HDG_Q3, 32'sd65536, 32'sd0, 16'sd0},
              1, {32'sd0, -32'sd65536, HDG_Q3, 1'b0});
      // heading sum reaching +pi wraps to -pi
      add_row({FUNC_COMPOSE, 32'sd0, 32'sd0, HDG_Q1, 32'sd0, 32'sd0, HDG_Q1},
              1, {32'sd0, 32'sd0, HDG_PI, 1'b0});
      add_row({FUNC_COMPOSE, POS_MAX, POS_MAX, 16'sd0, 32'sd1, 32'sd1, 16'sd0},
              1, {POS_MAX, POS_MAX, 16'sd0, 1'b1});
      add_row({FUNC_COMPOSE, POS_MIN, POS_MIN, 16'sd0, -32'sd1, -32'sd1, 16'sd0},
              1, {POS_MIN, POS_MIN, 16'sd0, 1'b1});
      // negating the most negative position saturates
      add_row({FUNC_INVERSE, POS_MIN, 32'sd0, 16'sd0, POS_MAX, POS_MAX, 16'sd77},
              1, {POS_MAX, 32'sd0, 16'sd0, 1'b1});
      // inverse at -pi keeps heading -pi
      add_row({FUNC_INVERSE, POS_MIN, 32'sd65536, HDG_PI, 32'sd0, 32'sd0, 16'sd0},
              1, {POS_MIN, 32'sd65536, HDG_PI, 1'b0});
      add_row({FUNC_INVERSE, 32'sd65536, 32'sd131072, HDG_Q1, 32'sd0, 32'sd0, 16'sd0},
              1, {-32'sd131072, 32'sd65536, -16'sd16384, 1'b0});
      add_row({FUNC_COMPOSE, 32'sd1000, -32'sd7, 16'sd1, 32'sd65536, 32'sd65536, 16'sd5}, 0, none);
      add_row({FUNC_COMPOSE, 32'sd0, 32'sd0, -16'sd1, POS_MAX, POS_MIN, 16'sd32767}, 0, none);
      add_row({FUNC_COMPOSE, POS_MAX, POS_MIN, 16'sd8192, POS_MAX, POS_MAX, HDG_PI}, 0, none);
      add_row({FUNC_COMPOSE, 32'sd12345, 32'sd6789, 16'sd32767, 32'sd99999, -32'sd5, 16'sd1},
              0, none);
      add_row({FUNC_COMPOSE, -32'sd1, 32'sd1, -16'sd32767, POS_MIN, POS_MIN, -16'sd1}, 0, none);
      add_row({FUNC_INVERSE, POS_MAX, POS_MAX, 16'sd16383, 32'sd0, 32'sd0, 16'sd0}, 0, none);
      add_row({FUNC_INVERSE, 32'sd3141592, -32'sd2718281, 16'sd12345, 32'sd0, 32'sd0, 16'sd0},
              0, none);
      add_row({FUNC_INVERSE, POS_MIN, POS_MIN, -16'sd16385, 32'sd1, 32'sd1, 16'sd1}, 0, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (table_req[i]) send_pose(table_req[i], table_typed[i], table_res[i]);

      // Random phases: sender/receiver idling swapped, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
         recv_idle = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            r.func = 1'($urandom);
            r.ax   = rand_pos();
            r.ay   = rand_pos();
            r.ah   = rand_hdg();
            r.bx   = rand_pos();
            r.by   = rand_pos();
            r.bh   = rand_hdg();
            send_pose(r, 0, none);
         end
         if (phase == 0) wait_drained();
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_poses.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (!failed && pending_poses.size() == 0) begin
         $display("pose_compose_inverse_2d: match");
      end else begin
         if (pending_poses.size() != 0)
            $display("%0t: %0d responses missing", $time, pending_poses.size());
         $display("pose_compose_inverse_2d: mismatch");
      end
      $finish;
   end

endmodule
